// ----- design/bper_pkg.sv -----
// Shared constants, types and codes of the button press event router.
package bper_pkg;

  localparam int NUM_BUTTONS = 16;
  localparam int NUM_TARGETS = 2;
  localparam int NUM_ACTIONS = 3;
  localparam int TABLE_SIZE  = NUM_BUTTONS * NUM_TARGETS * NUM_ACTIONS;
  localparam int TBL_AW      = $clog2(TABLE_SIZE);
  localparam int BTN_W       = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
  localparam int TGT_W       = (NUM_TARGETS > 1) ? $clog2(NUM_TARGETS) : 1;
  localparam int CFG_IDX_W   = 8;

  localparam logic [7:0]  UNSET         = 8'hFF;
  localparam logic [15:0] SHORT_MS_RST  = 16'd60;
  localparam logic [15:0] LONG_MS_RST   = 16'd500;

  localparam logic [CFG_IDX_W-1:0] REG_SHORT_MS = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_MS  = 8'd1;

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_PULSE = 2'd1;
  localparam logic [1:0] PH_HOLD  = 2'd2;

  localparam logic [1:0] EV_PULSE   = 2'd0;
  localparam logic [1:0] EV_HOLD    = 2'd1;
  localparam logic [1:0] EV_RELEASE = 2'd2;

  localparam logic KIND_ROUTED = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  typedef struct packed {
    logic [7:0] dest;
    logic [7:0] child;
    logic [7:0] payload;
  } entry_t;

  typedef struct packed {
    logic       kind;
    logic [3:0] which_button;
    logic [1:0] event_res;
    logic [7:0] dest;
    logic [7:0] child;
    logic [7:0] payload;
  } res_t;

endpackage

// ----- design/bper_alu.sv -----
// Shared 32-bit subtract and unsigned compare unit.
module bper_alu (
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] diff,
  output logic        ge
);
  logic [32:0] full;

  // carry out of a + ~b + 1 is set when a >= b
  assign full = {1'b0, a} + {1'b0, ~b} + 33'd1;
  assign diff = full[31:0];
  assign ge   = full[32];
endmodule

// ----- design/bper_table.sv -----
// Action table: one write port, one registered read port, valid bits for reset.
module bper_table (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     wr_en,
  input  logic [bper_pkg::TBL_AW-1:0] wr_addr,
  input  bper_pkg::entry_t         wr_data,
  input  logic                     rd_en,
  input  logic [bper_pkg::TBL_AW-1:0] rd_addr,
  output bper_pkg::entry_t         rd_data
);
  import bper_pkg::*;

  entry_t                mem [TABLE_SIZE];
  logic [TABLE_SIZE-1:0] valid;
  entry_t                rd_q;
  logic                  rd_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q   <= mem[rd_addr];
      rd_vld <= valid[rd_addr];
    end
  end

  // entries never written read as unset
  assign rd_data = rd_vld ? rd_q : entry_t'{dest: UNSET, child: UNSET, payload: UNSET};
endmodule

// ----- design/button_press_event_router.sv -----
// Top level: per-button press timing sequencer, action routing and output stage.
// A write item is taken in S_IDLE. A scan walks the buttons one by one: a button
// with no timed press, a first press or a release without event moves on from
// S_SUB, a timed press goes on through S_CMPS and S_CMPL (one shared subtractor
// computes the elapsed time, then compares it with short_ms and then long_ms),
// and each event reads each target slot on the single table read port (S_RD,
// S_CHK) plus S_REP for an unrouted report, then S_FLUSH closes the scan.
// A scan also waits while m_tready is low and the output stage is full.
// Results pass through a one-deep holding stage and an output register so
// tlast can mark the final result of each scan. The action table needs no
// clearing pass: valid bits reset with the block.
module button_press_event_router (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // time_ms[31:0], levels[47:32], button[51:48], target[59:52], action[67:60],
  // dest_in[75:68], child_in[83:76], payload_in[91:84], zero[95:92]
  input  logic [95:0]                   s_tdata,
  // op
  input  logic                          s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // which_button[3:0], event_res[5:4], dest_out[13:6], child_out[21:14],
  // payload_out[29:22], zero[31:30]
  output logic [31:0]                   m_tdata,
  // kind
  output logic                          m_tuser,
  output logic                          m_tlast,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bper_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                   cfg_data
);
  import bper_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_SUB   = 8'b0000_0010,
    S_CMPS  = 8'b0000_0100,
    S_CMPL  = 8'b0000_1000,
    S_RD    = 8'b0001_0000,
    S_CHK   = 8'b0010_0000,
    S_REP   = 8'b0100_0000,
    S_FLUSH = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  logic [15:0] short_ms, long_ms;
  logic [31:0] now;
  logic [NUM_BUTTONS-1:0] lv;
  logic [NUM_BUTTONS-1:0] timing;
  logic [1:0]  phase [NUM_BUTTONS];
  logic [31:0] press_start [NUM_BUTTONS];
  logic [BTN_W-1:0] bidx;
  logic [TGT_W-1:0] tidx;
  logic [31:0] el;
  logic [1:0]  ev;
  logic        handled;

  logic [31:0] alu_a, alu_b, alu_diff;
  logic        alu_ge;

  logic             tbl_wr, tbl_rd;
  logic [TBL_AW-1:0] tbl_waddr, tbl_raddr;
  entry_t           tbl_rdata;
  logic             entry_set;

  logic       push, flush, move, out_free, can_push;
  res_t       push_data, pend, out_r;
  logic       pend_valid, out_valid, out_last;

  logic       in_fire, pressed, last_btn;
  logic [3:0] btn_in;
  logic [7:0] tgt_in, act_in;
  int         tg_sat, ac_sat;
  logic [BTN_W+3:0] bidx_ext;
  logic [NUM_BUTTONS+15:0] lv_ext;

  assign in_fire   = s_tvalid && s_tready;
  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  assign btn_in = s_tdata[51:48];
  assign tgt_in = s_tdata[59:52];
  assign act_in = s_tdata[67:60];
  assign tg_sat = (int'(tgt_in) > NUM_TARGETS - 1) ? NUM_TARGETS - 1 : int'(tgt_in);
  assign ac_sat = (int'(act_in) > NUM_ACTIONS - 1) ? NUM_ACTIONS - 1 : int'(act_in);
  assign lv_ext = {{NUM_BUTTONS{1'b0}}, s_tdata[47:32]};

  assign tbl_wr    = in_fire && s_tuser && (int'(btn_in) < NUM_BUTTONS);
  assign tbl_waddr = TBL_AW'((int'(btn_in) * NUM_TARGETS + tg_sat) * NUM_ACTIONS + ac_sat);
  assign tbl_raddr = TBL_AW'((int'(bidx) * NUM_TARGETS + int'(tidx)) * NUM_ACTIONS + int'(ev));

  bper_table u_table (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (tbl_wr),
    .wr_addr (tbl_waddr),
    .wr_data (entry_t'{dest: s_tdata[75:68], child: s_tdata[83:76],
                       payload: s_tdata[91:84]}),
    .rd_en   (tbl_rd),
    .rd_addr (tbl_raddr),
    .rd_data (tbl_rdata)
  );

  always_comb begin
    alu_a = el;
    alu_b = {16'd0, short_ms};
    unique case (state)
      S_SUB: begin
        alu_a = now;
        alu_b = press_start[bidx];
      end
      S_CMPL:  alu_b = {16'd0, long_ms};
      default: ;
    endcase
  end

  bper_alu u_alu (
    .a    (alu_a),
    .b    (alu_b),
    .diff (alu_diff),
    .ge   (alu_ge)
  );

  assign pressed   = lv[bidx];
  assign last_btn  = (bidx == BTN_W'(NUM_BUTTONS - 1));
  assign entry_set = (tbl_rdata.dest != UNSET) && (tbl_rdata.child != UNSET);
  assign out_free  = !out_valid || m_tready;
  assign can_push  = !pend_valid || out_free;
  assign bidx_ext  = {4'd0, bidx};

  always_comb begin
    state_next = state;
    push       = 1'b0;
    flush      = 1'b0;
    tbl_rd     = 1'b0;
    push_data  = '{kind: KIND_ROUTED, which_button: bidx_ext[3:0], event_res: ev,
                   dest: tbl_rdata.dest, child: tbl_rdata.child,
                   payload: tbl_rdata.payload};
    unique case (state)
      S_IDLE: begin
        if (in_fire && !s_tuser) state_next = S_SUB;
      end
      S_SUB: begin
        if (pressed && timing[bidx]) begin
          state_next = S_CMPS;
        end else if (!pressed && phase[bidx] != PH_IDLE) begin
          state_next = S_RD;
        end else begin
          state_next = last_btn ? S_FLUSH : S_SUB;
        end
      end
      S_CMPS: state_next = S_CMPL;
      S_CMPL: begin
        if (alu_ge && phase[bidx] == PH_PULSE) state_next = S_RD;
        else state_next = last_btn ? S_FLUSH : S_SUB;
      end
      S_RD: begin
        tbl_rd     = 1'b1;
        state_next = S_CHK;
      end
      S_CHK: begin
        if (!entry_set || can_push) begin
          push = entry_set;
          if (tidx != TGT_W'(NUM_TARGETS - 1)) state_next = S_RD;
          else if (!(handled || entry_set)) state_next = S_REP;
          else state_next = last_btn ? S_FLUSH : S_SUB;
        end
      end
      S_REP: begin
        push_data.kind    = KIND_REPORT;
        push_data.dest    = 8'd0;
        push_data.child   = 8'd0;
        push_data.payload = 8'd0;
        if (can_push) begin
          push       = 1'b1;
          state_next = last_btn ? S_FLUSH : S_SUB;
        end
      end
      S_FLUSH: begin
        flush = pend_valid;
        if (!pend_valid || out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      short_ms <= SHORT_MS_RST;
      long_ms  <= LONG_MS_RST;
      timing   <= '0;
      for (int i = 0; i < NUM_BUTTONS; i++) phase[i] <= PH_IDLE;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_SHORT_MS) short_ms <= cfg_data;
        else if (cfg_index == REG_LONG_MS) long_ms <= cfg_data;
      end
      unique case (state)
        S_SUB: begin
          if (pressed && !timing[bidx]) begin
            timing[bidx] <= 1'b1;
          end else if (!pressed) begin
            timing[bidx] <= 1'b0;
            phase[bidx]  <= PH_IDLE;
          end
        end
        S_CMPS: begin
          if (alu_ge && phase[bidx] == PH_IDLE) phase[bidx] <= PH_PULSE;
        end
        S_CMPL: begin
          if (alu_ge && phase[bidx] == PH_PULSE) phase[bidx] <= PH_HOLD;
        end
        default: ;
      endcase
    end
  end

  // datapath registers of the sequencer
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        now  <= s_tdata[31:0];
        lv   <= lv_ext[NUM_BUTTONS-1:0];
        bidx <= '0;
      end
      S_SUB: begin
        tidx    <= '0;
        handled <= 1'b0;
        if (pressed && timing[bidx]) el <= alu_diff;
        if (pressed && !timing[bidx]) press_start[bidx] <= now;
        if (!pressed) ev <= (phase[bidx] == PH_HOLD) ? EV_RELEASE : EV_PULSE;
        if (state_next == S_SUB) bidx <= bidx + 1'b1;
      end
      S_CMPL: begin
        ev <= EV_HOLD;
        if (state_next == S_SUB) bidx <= bidx + 1'b1;
      end
      S_CHK: begin
        if (state_next != S_CHK) handled <= handled || entry_set;
        if (state_next == S_RD) tidx <= tidx + 1'b1;
        if (state_next == S_SUB) bidx <= bidx + 1'b1;
      end
      S_REP: begin
        if (state_next == S_SUB) bidx <= bidx + 1'b1;
      end
      default: ;
    endcase
  end

  // holding stage keeps one result back so the last one of a scan can be marked
  assign move = pend_valid && (push || flush) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (move) out_valid <= 1'b1;
      else if (m_tready) out_valid <= 1'b0;
      if (push) pend_valid <= 1'b1;
      else if (move) pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_r    <= pend;
      out_last <= flush;
    end
    if (push) pend <= push_data;
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_r.kind;
  assign m_tlast  = out_last;
  assign m_tdata  = {2'b00, out_r.payload, out_r.child, out_r.dest, out_r.event_res,
                     out_r.which_button};

  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !pend_valid)
    else $error("result left in holding stage after scan");

  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    push && pend_valid |-> out_free)
    else $error("result pushed with no room downstream");

  a_untimed_idle: assert property (@(posedge clk) disable iff (rst)
    !timing[bidx] |-> phase[bidx] == PH_IDLE)
    else $error("button phase advanced without a timed press");

  a_flush_last: assert property (@(posedge clk) disable iff (rst)
    move && !flush |=> !m_tlast)
    else $error("tlast set on a result that is not the last of its scan");

endmodule
